>>> design/kmm_pkg.sv
// Shared types and constants of the keyed min/max tracker.
// Used by the channel interfaces, the tracker, its RAM and its checker.
// No dependencies.
package kmm_pkg;

    // Field widths of the item and result beats
    localparam int OP_W   = 2;
    localparam int ID_W   = 4;
    localparam int DATA_W = 16;

    // Defaults of the top-level parameters
    localparam int ENTRIES_DEF     = 16;
    localparam int VALUE_WIDTH_DEF = 16;

    // Empty-slot code after reset, and the "no maximum" mark
    localparam logic [DATA_W-1:0] EMPTY_RST = '0;
    localparam logic [DATA_W-1:0] NO_MAX    = '0;

    typedef enum logic [OP_W-1:0] {
        OP_SET       = 2'd0,
        OP_SET_UPPER = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_CLEAR_ALL = 2'd3
    } t_op;

endpackage

>>> design/kmm_ifs.sv
// Valid/ready channel interfaces of the keyed min/max tracker.
// Depends on kmm_pkg for the field widths.
interface kmm_item_if;
    logic                         valid;
    logic                         ready;
    logic [kmm_pkg::OP_W-1:0]     operation;
    logic [kmm_pkg::ID_W-1:0]     entry_id;
    logic [kmm_pkg::DATA_W-1:0]   value;

    modport source (output valid, operation, entry_id, value, input ready);
    modport sink   (input valid, operation, entry_id, value, output ready);
endinterface

interface kmm_result_if;
    logic                         valid;
    logic                         ready;
    logic                         is_limit;
    logic [kmm_pkg::DATA_W-1:0]   min_value;
    logic [kmm_pkg::DATA_W-1:0]   max_value;

    modport source (output valid, is_limit, min_value, max_value, input ready);
    modport sink   (input valid, is_limit, min_value, max_value, output ready);
endinterface

>>> design/kmm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on kmm_pkg for default sizes.
module kmm_ram #(
    parameter int WIDTH = kmm_pkg::VALUE_WIDTH_DEF,
    parameter int DEPTH = kmm_pkg::ENTRIES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/keyed_min_max_tracker_unit.sv
// Keyed running min/max tracker: slot table in RAM plus running extremes.
// Depends on kmm_pkg, kmm_item_if / kmm_result_if and kmm_ram.
//
// Usage:
//   i_item carries one operation per beat (set, set upper, clear entry,
//   clear all) with entry_id and value. o_result returns exactly one beat
//   per item: is_limit and the minimum and maximum after the operation.
//   i_cfg_wr_en / i_cfg_wr_data write the empty-slot code; write it only
//   while no item is in flight.
// Operation flow:
//   Set, set upper, clear all and out-of-range ids: result registered in the
//   cycle after the item beat, next item accepted the cycle after unless o_result.ready is low.
//   Clear that misses both extremes: one RAM read of the old value, compared in S_CLR.
//   Clear that hits an extreme: S_CLR, then a rescan in S_SCAN that reads the
//   slot RAM one entry per cycle through its single read port.
// Reset: slots read as the empty code (per-entry valid bits, no RAM sweep),
//   minimum goes to all ones in VALUE_WIDTH bits, maximum to zero, no result pending.
// Stall: a result holds in the output register while o_result.ready is low;
//   the item channel is not ready until that register can take a new beat.
module keyed_min_max_tracker_unit #(
    parameter int ENTRIES     = kmm_pkg::ENTRIES_DEF,
    parameter int VALUE_WIDTH = kmm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [kmm_pkg::DATA_W-1:0]  i_cfg_wr_data,
    kmm_item_if.sink                    i_item,
    kmm_result_if.source                o_result
);

    localparam int DW     = kmm_pkg::DATA_W;
    localparam int SLOT_W = (VALUE_WIDTH > DW) ? VALUE_WIDTH : DW;
    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam logic [SLOT_W-1:0] SLOT_TOP    = SLOT_W'((64'd1 << VALUE_WIDTH) - 64'd1);
    localparam logic [SLOT_W-1:0] SLOT_BOTTOM = SLOT_W'(kmm_pkg::NO_MAX);
    localparam logic [CW-1:0]     LAST_CNT    = CW'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CLR  = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [DW-1:0]       r_empty_code;
    logic [DW-1:0]       r_fill_code, n_fill_code;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [SLOT_W-1:0]   r_min, n_min;
    logic [SLOT_W-1:0]   r_max, n_max;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_chk, n_chk;
    logic [AW-1:0]       r_chk_idx, n_chk_idx;
    logic [SLOT_W-1:0]   r_lo, n_lo;
    logic [SLOT_W-1:0]   r_hi, n_hi;
    logic                r_out_valid, n_out_valid;
    logic                r_out_limit, n_out_limit;
    logic [DW-1:0]       r_out_min, n_out_min;
    logic [DW-1:0]       r_out_max, n_out_max;

    logic                w_out_free;
    logic                w_accept;
    kmm_pkg::t_op        w_op;
    logic                w_in_range;
    logic [AW-1:0]       w_in_addr;
    logic [VALUE_WIDTH-1:0] w_val_vw;
    logic [SLOT_W-1:0]   w_in_val;
    logic [SLOT_W-1:0]   w_empty;
    logic [SLOT_W-1:0]   w_fill;
    logic [SLOT_W-1:0]   w_rd_data;
    logic [SLOT_W-1:0]   w_old;
    logic [SLOT_W-1:0]   w_scan_val;
    logic                w_hit;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [SLOT_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;

    assign w_out_free = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept = i_item.valid && i_item.ready;
    assign w_op = kmm_pkg::t_op'(i_item.operation);
    assign w_in_range = (32'(i_item.entry_id) < 32'(ENTRIES));
    assign w_in_addr = AW'(i_item.entry_id);
    assign w_val_vw = VALUE_WIDTH'(i_item.value);
    assign w_in_val = SLOT_W'(w_val_vw);
    assign w_empty = SLOT_W'(r_empty_code);
    assign w_fill = SLOT_W'(r_fill_code);

    // Entries never written since the last fill read as the fill code
    assign w_old = r_valid[r_addr] ? w_rd_data : w_fill;
    assign w_scan_val = r_valid[r_chk_idx] ? w_rd_data : w_fill;
    assign w_hit = (w_old == r_min) || (w_old == r_max);

    always_comb begin
        n_state     = r_state;
        n_fill_code = r_fill_code;
        n_valid     = r_valid;
        n_min       = r_min;
        n_max       = r_max;
        n_addr      = r_addr;
        n_rd_idx    = r_rd_idx;
        n_chk       = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_limit = r_out_limit;
        n_out_min   = r_out_min;
        n_out_max   = r_out_max;
        ram_wr_en   = 1'b0;
        ram_wr_addr = w_in_addr;
        ram_wr_data = w_in_val;
        ram_rd_en   = 1'b0;
        ram_rd_addr = w_in_addr;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_addr      = w_in_addr;
                    n_out_valid = 1'b1;
                    n_out_limit = 1'b0;
                    n_out_min   = r_min[DW-1:0];
                    n_out_max   = r_max[DW-1:0];
                    if (w_op == kmm_pkg::OP_CLEAR_ALL) begin
                        n_valid     = '0;
                        n_fill_code = r_empty_code;
                        n_min       = SLOT_TOP;
                        n_max       = SLOT_BOTTOM;
                        n_out_min   = SLOT_TOP[DW-1:0];
                        n_out_max   = SLOT_BOTTOM[DW-1:0];
                    end else if (w_in_range) begin
                        if (w_op == kmm_pkg::OP_CLEAR) begin
                            // fetch the old value; the result comes after the compare
                            ram_rd_en   = 1'b1;
                            n_out_valid = 1'b0;
                            n_state     = S_CLR;
                        end else begin
                            ram_wr_en            = 1'b1;
                            n_valid[w_in_addr]   = 1'b1;
                            if (w_in_val < r_min) begin
                                n_min       = w_in_val;
                                n_out_limit = 1'b1;
                            end
                            if ((w_op == kmm_pkg::OP_SET) && (w_in_val > r_max)) begin
                                n_max       = w_in_val;
                                n_out_limit = 1'b1;
                            end
                            n_out_min = n_min[DW-1:0];
                            n_out_max = n_max[DW-1:0];
                        end
                    end
                end
            end
            S_CLR: begin
                ram_wr_en         = 1'b1;
                ram_wr_addr       = r_addr;
                ram_wr_data       = w_empty;
                n_valid[r_addr]   = 1'b1;
                if (w_hit) begin
                    n_rd_idx = '0;
                    n_lo     = SLOT_TOP;
                    n_hi     = SLOT_BOTTOM;
                    n_state  = S_SCAN;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_limit = 1'b0;
                    n_out_min   = r_min[DW-1:0];
                    n_out_max   = r_max[DW-1:0];
                    n_state     = S_IDLE;
                end
            end
            S_SCAN: begin
                // issue one read per cycle, compare the entry read the cycle before
                if (r_rd_idx != LAST_CNT) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_rd_idx[AW-1:0];
                    n_chk       = 1'b1;
                    n_chk_idx   = r_rd_idx[AW-1:0];
                    n_rd_idx    = r_rd_idx + CW'(1);
                end
                if (r_chk && (w_scan_val != w_empty)) begin
                    if (w_scan_val < r_lo) begin
                        n_lo = w_scan_val;
                    end
                    if (w_scan_val > r_hi) begin
                        n_hi = w_scan_val;
                    end
                end
                if (r_chk && (r_rd_idx == LAST_CNT)) begin
                    n_min       = n_lo;
                    n_max       = n_hi;
                    n_out_valid = 1'b1;
                    n_out_limit = 1'b1;
                    n_out_min   = n_lo[DW-1:0];
                    n_out_max   = n_hi[DW-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_empty_code <= kmm_pkg::EMPTY_RST;
            r_fill_code  <= kmm_pkg::EMPTY_RST;
            r_valid      <= '0;
            r_min        <= SLOT_TOP;
            r_max        <= SLOT_BOTTOM;
            r_chk        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_wr_en) begin
                r_empty_code <= i_cfg_wr_data;
            end
            r_fill_code  <= n_fill_code;
            r_valid      <= n_valid;
            r_min        <= n_min;
            r_max        <= n_max;
            r_chk        <= n_chk;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_rd_idx    <= n_rd_idx;
        r_chk_idx   <= n_chk_idx;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_out_limit <= n_out_limit;
        r_out_min   <= n_out_min;
        r_out_max   <= n_out_max;
    end

    kmm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_result.valid     = r_out_valid;
    assign o_result.is_limit  = r_out_limit;
    assign o_result.min_value = r_out_min;
    assign o_result.max_value = r_out_max;

endmodule

>>> design/kmm_checker.sv
// Port-level checker of the keyed min/max tracker, bound to the top level.
// Depends on kmm_pkg for field widths and operation codes.
module kmm_checker #(
    parameter int ENTRIES = kmm_pkg::ENTRIES_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic [kmm_pkg::OP_W-1:0]    i_in_operation,
    input logic [kmm_pkg::ID_W-1:0]    i_in_entry_id,
    input logic [kmm_pkg::DATA_W-1:0]  i_in_value,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_is_limit,
    input logic [kmm_pkg::DATA_W-1:0]  i_out_min_value,
    input logic [kmm_pkg::DATA_W-1:0]  i_out_max_value
);

    logic w_in_beat;
    logic w_set_op;

    assign w_in_beat = i_in_valid && i_in_ready;
    assign w_set_op  = (i_in_operation == kmm_pkg::OP_SET) ||
                       (i_in_operation == kmm_pkg::OP_SET_UPPER);

    // Nothing pending after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_is_limit) && $stable(i_out_min_value) &&
            $stable(i_out_max_value))
        else $error("stalled result changed");

    // A waiting result blocks new items
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("item taken while result stalled");

    // Clear all answers next cycle with no extreme and no limit flag
    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && (i_in_operation == kmm_pkg::OP_CLEAR_ALL) |=>
            i_out_valid && !i_out_is_limit && (i_out_max_value == '0))
        else $error("clear all result wrong");

    // A stored value bounds the minimum from above
    a_set_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && w_set_op && (32'(i_in_entry_id) < 32'(ENTRIES)) |=>
            i_out_valid && (i_out_min_value <= $past(i_in_value)))
        else $error("minimum above stored value");

endmodule

bind keyed_min_max_tracker_unit kmm_checker #(
    .ENTRIES (ENTRIES)
) u_kmm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_in_operation  (i_item.operation),
    .i_in_entry_id   (i_item.entry_id),
    .i_in_value      (i_item.value),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_out_is_limit  (o_result.is_limit),
    .i_out_min_value (o_result.min_value),
    .i_out_max_value (o_result.max_value)
);
